// ----- rtl/core/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants for the rgb / hsl colour converter core
// ----------------------------------------------------------------------------
package rhc_pkg;

    // direction of one pixel beat
    typedef enum logic {
        CMD_RGB2HSL = 1'b0,
        CMD_HSL2RGB = 1'b1
    } t_cmd;

    // q1.15 fixed point
    localparam logic [15:0] ONE_Q15  = 16'h8000;
    localparam logic [15:0] HALF_Q15 = 16'h4000;

    // floor(y / 255) == (y * 0x8081) >> 23 for any 16-bit y
    localparam logic [15:0] RECIP_255 = 16'h8081;

    // divider: 11-bit operands, one integer bit plus 15 fraction bits
    localparam int DIV_W = 11;
    localparam int QUO_W = 16;

    // side data leaves the front pipe after six stages and waits for the divider
    localparam int FRONT_STAGES = 6;
    localparam int SIDE_DLY     = QUO_W + 1 - FRONT_STAGES;

    typedef struct packed {
        t_cmd       cmd;
        logic       gray;
        logic [15:0] light;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_side;

endpackage

// ----- rtl/core/rhc_div.sv -----
// ----------------------------------------------------------------------------
// rhc_div
// pipelined restoring divider, q = floor(a * 2^15 / b) for a <= b,
// one quotient bit per stage
// ----------------------------------------------------------------------------
module rhc_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rhc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [rhc_pkg::DIV_W-1:0]  i_divisor,
    output logic [rhc_pkg::QUO_W-1:0]  o_quotient
);

    localparam int W = rhc_pkg::DIV_W;
    localparam int N = rhc_pkg::QUO_W;

    logic [W-1:0] r_rem [N];
    logic [N-1:0] r_quo [N];
    logic [W-1:0] r_div [N-1];
    logic [W-1:0] n_rem [N];
    logic [N-1:0] n_quo [N];
    logic [W-1:0] n_div [N-1];

    always_comb begin
        logic [W-1:0] src_rem;
        logic [W-1:0] src_div;
        logic [N-1:0] src_quo;
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         q_bit;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                // integer bit: no shift
                src_rem = i_dividend;
                src_div = i_divisor;
                src_quo = '0;
                trial   = {1'b0, src_rem};
            end else begin
                src_rem = r_rem[k-1];
                src_div = r_div[k-1];
                src_quo = r_quo[k-1];
                trial   = {src_rem, 1'b0};
            end
            q_bit    = (trial >= {1'b0, src_div});
            diff     = trial - {1'b0, src_div};
            n_rem[k] = q_bit ? diff[W-1:0] : trial[W-1:0];
            n_quo[k] = {src_quo[N-2:0], q_bit};
            if (k < N - 1) begin
                n_div[k] = src_div;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 0; k < N - 1; k++) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    assign o_quotient = r_quo[N-1];

endmodule

// ----- rtl/core/rgb_hsl_color_converter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_core
// one-pixel-per-beat converter between 8-bit rgb and q1.15 hsl
// ----------------------------------------------------------------------------
// Takes one pixel beat every clock cycle while not stalled and returns one
// result beat per pixel, in order. The latency is set by the two
// 16-stage restoring dividers that produce saturation and hue (one quotient
// bit per stage); the hsl to rgb path and the lightness path finish earlier
// and wait in a delay line. A stall of a valid output freezes the whole pipe
// and is passed back to the input in the same cycle. Command 0 fills hue,
// sat and light and zeroes the channel bytes; command 1 does the opposite.
module rgb_hsl_color_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [15:0] i_hue_in,
    input  logic [15:0] i_sat_in,
    input  logic [15:0] i_light_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [15:0] o_hue_out,
    output logic [15:0] o_sat_out,
    output logic [15:0] o_light_out
);

    localparam int VLD_N = rhc_pkg::QUO_W + 1;
    localparam int DW    = rhc_pkg::DIV_W;

    function automatic logic [15:0] clamp_one(input logic [15:0] x);
        clamp_one = (x > rhc_pkg::ONE_Q15) ? rhc_pkg::ONE_Q15 : x;
    endfunction

    function automatic logic [7:0] to_byte(input logic [15:0] x);
        logic [23:0] p;
        p = {x, 8'b0} - {8'b0, x};
        to_byte = p[23] ? 8'hff : p[22:15];
    endfunction

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    logic [VLD_N-1:0] r_vld;

    // ---------------- stage 1: min / max, hue numerator, clamps
    logic [7:0]         c_mx, c_mn, c_d, c_den;
    logic [8:0]         c_sum, c_den_w;
    logic signed [11:0] c_n, s_r, s_g, s_b, s_d;

    always_comb begin
        c_mx = i_red_in;
        c_mn = i_red_in;
        if (i_green_in > c_mx) c_mx = i_green_in;
        if (i_blue_in > c_mx)  c_mx = i_blue_in;
        if (i_green_in < c_mn) c_mn = i_green_in;
        if (i_blue_in < c_mn)  c_mn = i_blue_in;
        c_d     = c_mx - c_mn;
        c_sum   = {1'b0, c_mx} + {1'b0, c_mn};
        c_den_w = 9'd510 - c_sum;
        c_den   = (c_sum < 9'd255) ? c_sum[7:0] : c_den_w[7:0];
        s_r = signed'({4'b0, i_red_in});
        s_g = signed'({4'b0, i_green_in});
        s_b = signed'({4'b0, i_blue_in});
        s_d = signed'({4'b0, c_d});
        if (i_red_in == c_mx) begin
            c_n = s_g - s_b;
        end else if (i_green_in == c_mx) begin
            c_n = (s_d <<< 1) + s_b - s_r;
        end else begin
            c_n = (s_d <<< 2) + s_r - s_g;
        end
        // wrap into one turn
        if (c_n < 0) c_n = c_n + (s_d <<< 2) + (s_d <<< 1);
    end

    rhc_pkg::t_cmd r1_cmd;
    logic [7:0]    r1_d, r1_den;
    logic [8:0]    r1_sum;
    logic [10:0]   r1_n;
    logic [15:0]   r1_h, r1_s, r1_l;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= rhc_pkg::t_cmd'(i_command);
            r1_d   <= c_d;
            r1_den <= c_den;
            r1_sum <= c_sum;
            r1_n   <= c_n[10:0];
            r1_h   <= clamp_one(i_hue_in);
            r1_s   <= clamp_one(i_sat_in);
            r1_l   <= clamp_one(i_light_in);
        end
    end

    // ---------------- dividers for saturation and hue
    logic [DW-1:0]            sat_a, sat_b, hue_a, hue_b;
    logic [rhc_pkg::QUO_W-1:0] sat_q, hue_q;

    assign sat_a = {{(DW-8){1'b0}}, r1_d};
    assign sat_b = {{(DW-8){1'b0}}, r1_den};
    assign hue_a = r1_n;
    assign hue_b = {1'b0, r1_d, 2'b0} + {2'b0, r1_d, 1'b0};

    rhc_div u_sat_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (sat_a),
        .i_divisor  (sat_b),
        .o_quotient (sat_q)
    );

    rhc_div u_hue_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (hue_a),
        .i_divisor  (hue_b),
        .o_quotient (hue_q)
    );

    // ---------------- stage 2: l * s, 6h, lightness product
    rhc_pkg::t_cmd r2_cmd;
    logic          r2_gray;
    logic [31:0]   r2_ls, r2_lp;
    logic [17:0]   r2_h6;
    logic [15:0]   r2_l, r2_s;
    logic [14:0]   r2_y;

    logic [14:0] c_y;
    assign c_y = {r1_sum, 6'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd  <= r1_cmd;
            r2_gray <= (r1_d == 8'd0);
            r2_ls   <= r1_l * r1_s;
            r2_h6   <= {r1_h, 2'b0} + {1'b0, r1_h, 1'b0};
            r2_l    <= r1_l;
            r2_s    <= r1_s;
            r2_y    <= c_y;
            r2_lp   <= {17'b0, c_y} * {16'b0, rhc_pkg::RECIP_255};
        end
    end

    // ---------------- stage 3: v, m, sextant, lightness
    logic [15:0]        c_lsq, c_v, c_m;
    logic [16:0]        c_v_w;
    logic signed [17:0] c_mi;

    always_comb begin
        c_lsq = r2_ls[30:15];
        if (r2_l <= rhc_pkg::HALF_Q15) begin
            c_v_w = {1'b0, r2_l} + {1'b0, c_lsq};
        end else begin
            c_v_w = {1'b0, r2_l} + {1'b0, r2_s} - {1'b0, c_lsq};
        end
        c_v  = c_v_w[15:0];
        c_mi = signed'({1'b0, r2_l, 1'b0}) - signed'({2'b0, c_v});
        if (c_mi < 0) begin
            c_m = '0;
        end else if (c_mi > signed'({2'b0, c_v})) begin
            c_m = c_v;
        end else begin
            c_m = c_mi[15:0];
        end
    end

    rhc_pkg::t_cmd r3_cmd;
    logic          r3_gray;
    logic [15:0]   r3_v, r3_m, r3_l, r3_light;
    logic [2:0]    r3_sext;
    logic [14:0]   r3_f;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd   <= r2_cmd;
            r3_gray  <= r2_gray;
            r3_v     <= c_v;
            r3_m     <= c_m;
            r3_l     <= r2_l;
            r3_sext  <= r2_h6[17:15];
            r3_f     <= r2_h6[14:0];
            r3_light <= {1'b0, r2_y} + {8'b0, r2_lp[30:23]};
        end
    end

    // ---------------- stage 4: (v - m) * f
    rhc_pkg::t_cmd r4_cmd;
    logic          r4_gray;
    logic [30:0]   r4_prod;
    logic [15:0]   r4_v, r4_m, r4_l, r4_light;
    logic [2:0]    r4_sext;

    logic [15:0] c_vm;
    assign c_vm = r3_v - r3_m;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cmd   <= r3_cmd;
            r4_gray  <= r3_gray;
            r4_prod  <= c_vm * r3_f;
            r4_v     <= r3_v;
            r4_m     <= r3_m;
            r4_l     <= r3_l;
            r4_sext  <= r3_sext;
            r4_light <= r3_light;
        end
    end

    // ---------------- stage 5: sextant select
    logic [15:0] c_q, c_mid1, c_mid2, c_rc, c_gc, c_bc;

    always_comb begin
        c_q    = r4_prod[30:15];
        c_mid1 = r4_m + c_q;
        c_mid2 = r4_v - c_q;
        c_rc   = r4_l;
        c_gc   = r4_l;
        c_bc   = r4_l;
        if (r4_v != 16'd0) begin
            case (r4_sext)
                3'd0: begin c_rc = r4_v;    c_gc = c_mid1; c_bc = r4_m;    end
                3'd1: begin c_rc = c_mid2;  c_gc = r4_v;   c_bc = r4_m;    end
                3'd2: begin c_rc = r4_m;    c_gc = r4_v;   c_bc = c_mid1;  end
                3'd3: begin c_rc = r4_m;    c_gc = c_mid2; c_bc = r4_v;    end
                3'd4: begin c_rc = c_mid1;  c_gc = r4_m;   c_bc = r4_v;    end
                3'd5: begin c_rc = r4_v;    c_gc = r4_m;   c_bc = c_mid2;  end
                // hue of a full turn: gray
                default: begin c_rc = r4_l; c_gc = r4_l;   c_bc = r4_l;    end
            endcase
        end
    end

    rhc_pkg::t_cmd r5_cmd;
    logic          r5_gray;
    logic [15:0]   r5_r, r5_g, r5_b, r5_light;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_cmd   <= r4_cmd;
            r5_gray  <= r4_gray;
            r5_r     <= c_rc;
            r5_g     <= c_gc;
            r5_b     <= c_bc;
            r5_light <= r4_light;
        end
    end

    // ---------------- stage 6: byte scaling, then wait for the dividers
    rhc_pkg::t_side r6_side;
    rhc_pkg::t_side r_dly [rhc_pkg::SIDE_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side.cmd   <= r5_cmd;
            r6_side.gray  <= r5_gray;
            r6_side.light <= r5_light;
            r6_side.red   <= to_byte(r5_r);
            r6_side.green <= to_byte(r5_g);
            r6_side.blue  <= to_byte(r5_b);
            r_dly[0]      <= r6_side;
            for (int k = 1; k < rhc_pkg::SIDE_DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    rhc_pkg::t_side side_q;
    assign side_q = r_dly[rhc_pkg::SIDE_DLY-1];

    // ---------------- output register
    logic [7:0]  r_o_red, r_o_green, r_o_blue;
    logic [15:0] r_o_hue, r_o_sat, r_o_light;
    logic        r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[VLD_N-2:0], i_valid};
            r_o_vld <= r_vld[VLD_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (side_q.cmd == rhc_pkg::CMD_HSL2RGB) begin
                r_o_red   <= side_q.red;
                r_o_green <= side_q.green;
                r_o_blue  <= side_q.blue;
                r_o_hue   <= '0;
                r_o_sat   <= '0;
                r_o_light <= '0;
            end else begin
                r_o_red   <= '0;
                r_o_green <= '0;
                r_o_blue  <= '0;
                r_o_hue   <= side_q.gray ? 16'd0 : hue_q;
                r_o_sat   <= side_q.gray ? 16'd0 : sat_q;
                r_o_light <= side_q.light;
            end
        end
    end

    assign o_valid     = r_o_vld;
    assign o_red_out   = r_o_red;
    assign o_green_out = r_o_green;
    assign o_blue_out  = r_o_blue;
    assign o_hue_out   = r_o_hue;
    assign o_sat_out   = r_o_sat;
    assign o_light_out = r_o_light;

    // ---------------- checks
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result beat held");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipe valid bits moved during a stall");

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_red_out != 8'd0 || o_green_out != 8'd0 || o_blue_out != 8'd0))
        |-> (o_hue_out == 16'd0 && o_sat_out == 16'd0 && o_light_out == 16'd0))
        else $error("rgb and hsl fields both filled");

    a_q15_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_out < rhc_pkg::ONE_Q15 && o_sat_out <= rhc_pkg::ONE_Q15
                     && o_light_out <= rhc_pkg::ONE_Q15))
        else $error("hsl result above one");

endmodule
